// File: sv/sha256_pkg.sv
// sha-256 constants, types and round functions
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenWidth   = 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  typedef logic [31:0] word_t;

  localparam word_t KInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t KRound [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t sm_s0(input word_t x);
    sm_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sm_s1(input word_t x);
    sm_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: sv/sha256_byte_stream_hash.sv
// sha-256 hash of a byte stream, one byte per word, iterative round core
//
// Takes one message byte per input word. Bytes are packed straight into a
// 16-word schedule register. When 64 bytes are in, the block goes busy and
// runs the 64 compression rounds on one shared round unit, one round per
// cycle, then folds the working variables into the hash state. in_stall_o
// is high whenever the block is not idle, so also during the digest
// output. On a word marked last the 0x80 pad, zero fill and the 64-bit
// bit length are placed and one or two more blocks are compressed.
// Two blocks are needed when the pad lands
// at byte 56 or above, or when last rides on the byte that fills a block
// (that block first, then a block holding the pad and the length). Then
// the eight digest words come out one per handshake, index 0 (most
// significant) first, last_word on index 7. After the digest the hash
// state and the length return to their initial values. The bit length
// wraps modulo 2^64.
module sha256_byte_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  digest_pos_o,
  output logic        last_word_o
);
  import sha256_pkg::*;

  state_e state_q, state_d;

  word_t  h_q [8];
  word_t  v_q [8];
  word_t  w_q [16];
  logic [LenWidth-1:0] len_q;
  logic [5:0] rnd_q;
  // fin_q: digest pending after this compression; second_q: a length
  // block must follow this one
  logic fin_q, second_q;
  logic [2:0] idx_q;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  // shared round unit
  word_t wr, w_new, t1, t2;
  always_comb begin
    w_new = sm_s1(w_q[14]) + w_q[9] + sm_s0(w_q[1]) + w_q[0];
    wr    = (rnd_q < 6'd16) ? w_q[0] : w_new;
    t1    = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
          + KRound[rnd_q] + wr;
    t2    = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (byte_valid_i || last_i)) begin
          if (last_i || (byte_valid_i && len_q[5:0] == 6'd63)) state_d = ST_ROUND;
        end
      end
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (second_q)   state_d = ST_ROUND;
        else if (fin_q) state_d = ST_EMIT;
        else            state_d = ST_IDLE;
      end
      ST_EMIT: if (!out_stall_i && idx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = (state_q == ST_EMIT);
    digest_word_o = h_q[idx_q];
    digest_pos_o  = idx_q;
    last_word_o   = (idx_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      rnd_q    <= '0;
      fin_q    <= 1'b0;
      second_q <= 1'b0;
      idx_q    <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= KInit[i];
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          idx_q <= '0;
        end
        ST_EMIT: begin
          if (!out_stall_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= KInit[i];
              len_q <= '0;
              fin_q <= 1'b0;
            end
          end
        end
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_IDLE: begin
          rnd_q <= '0;
          if (accept) begin
            if (byte_valid_i) len_q <= len_q + LenWidth'(1);
            fin_q <= last_i;
            // pad at 56 or above, or last on the byte that fills the block
            second_q <= last_i &&
                        (((byte_valid_i ? len_q[5:0] + 6'd1 : len_q[5:0]) >= 6'd56) ||
                         (byte_valid_i && len_q[5:0] == 6'd63));
          end
        end
        default: ;
      endcase
      if (state_q == ST_ADD && second_q) second_q <= 1'b0;
    end
  end

  // datapath: schedule words and working variables, no reset needed
  logic [LenWidth-1:0] len_n;
  logic [5:0] pos;
  logic [63:0] bits;
  always_comb begin
    len_n = byte_valid_i ? len_q + LenWidth'(1) : len_q;
    pos   = len_n[5:0];
    bits  = {len_n, 3'b000};
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          word_t wl [16];
          for (int i = 0; i < 16; i++) wl[i] = w_q[i];
          if (byte_valid_i)
            wl[len_q[5:2]][8*(3-len_q[1:0]) +: 8] = data_byte_i;
          // a byte that fills the block leaves padding to the next block
          if (last_i && !(byte_valid_i && len_q[5:0] == 6'd63)) begin
            // pad byte then zero fill from pos on
            for (int b = 0; b < 64; b++) begin
              if (b[5:0] == pos) wl[b/4][8*(3-b%4) +: 8] = PadByte;
              else if (b[5:0] > pos) wl[b/4][8*(3-b%4) +: 8] = 8'h00;
            end
            if (pos < 6'd56) begin
              wl[14] = bits[63:32];
              wl[15] = bits[31:0];
            end
          end
          for (int i = 0; i < 16; i++) w_q[i] <= wl[i];
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wr;
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
      ST_ADD: begin
        if (second_q) begin
          // length block, pad byte first when the data ended on a block edge
          w_q[0] <= (len_q[5:0] == 6'd0) ? {PadByte, 24'h000000} : '0;
          for (int i = 1; i < 14; i++) w_q[i] <= '0;
          w_q[14] <= len_q[LenWidth-1:29];
          w_q[15] <= {len_q[28:0], 3'b000};
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i] + v_q[i];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: verif/tb_sha256_byte_stream_hash.sv
// self-checking testbench for the sha-256 byte stream hash block
module tb_sha256_byte_stream_hash;
  import sha256_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        byte_valid_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  digest_pos_o;
  logic        last_word_o;

  sha256_byte_stream_hash dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i), .byte_valid_i(byte_valid_i), .last_i(last_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .digest_word_o(digest_word_o), .digest_pos_o(digest_pos_o),
    .last_word_o(last_word_o)
  );

  // one input word as the driver sees it
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } msg_word_t;

  // one digest word as the monitor expects it
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_pos;
    logic        last_word;
  } digest_t;

  // idle phases: sender idle percent, receiver stall percent
  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} phase_e;

  msg_word_t pending_words[$];
  digest_t   digest_queue[$];

  // predictor state
  word_t       hstate [8];
  logic [7:0]  blk [64];
  logic [60:0] byte_count;

  int     errors;
  int     cycle_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_send;

  localparam int CycleLimit = 400000;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64-round compression of blk into hstate
  function automatic void compress_blk();
    word_t sched [16];
    word_t v [8];
    word_t w, w2, w15, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hstate[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w2  = sched[(r-2) & 15];
        w15 = sched[(r-15) & 15];
        w = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + sched[(r-7) & 15]
          + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + sched[r & 15];
        sched[r & 15] = w;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KRound[r] + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int k = 7; k > 0; k--) v[k] = v[k-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hstate[i] = hstate[i] + v[i];
  endfunction

  // advance the hash predictor by one accepted word
  function automatic void hash_accept(msg_word_t m);
    int unsigned pos;
    logic [63:0] bits;
    digest_t d;
    if (m.byte_valid) begin
      blk[byte_count[5:0]] = m.data_byte;
      byte_count = byte_count + 61'd1;
      if (byte_count[5:0] == 6'd0) compress_blk();
    end
    if (!m.last) return;
    pos = {26'd0, byte_count[5:0]};
    blk[pos] = PadByte;
    for (int i = pos + 1; i < 64; i++) blk[i] = 8'h00;
    if (pos >= 56) begin
      compress_blk();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    end
    bits = {byte_count, 3'b000};
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hstate[i];
      d.digest_pos  = 3'(i);
      d.last_word   = (i == 7);
      digest_queue = {digest_queue, d};
    end
    for (int i = 0; i < 8; i++) hstate[i] = KInit[i];
    byte_count = '0;
  endfunction

  // append one word to the pending queue
  task automatic queue_word(msg_word_t m);
    pending_words = {pending_words, m};
  endtask

  // queue a message of len random bytes; the last byte may ride with last
  task automatic push_message(int len, bit last_with_byte);
    msg_word_t m;
    for (int i = 0; i < len; i++) begin
      m.data_byte  = 8'($urandom);
      m.byte_valid = 1'b1;
      m.last       = last_with_byte && (i == len - 1);
      queue_word(m);
    end
    if (!last_with_byte || len == 0) begin
      m = '{data_byte: 8'($urandom), byte_valid: 1'b0, last: 1'b1};
      queue_word(m);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (digest_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_phase(phase_e ph);
    case (ph)
      PH_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PH_SEND: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      PH_RECV: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default: begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // driver: holds a word until accepted, then maybe idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_byte_i  <= '0;
      byte_valid_i <= 1'b0;
      last_i       <= 1'b0;
      for (int i = 0; i < 8; i++) hstate[i] = KInit[i];
      byte_count = '0;
    end else if (!in_valid_i || !in_stall_o) begin
      // current word (if any) taken this edge: feed the predictor
      if (in_valid_i)
        hash_accept('{data_byte: data_byte_i, byte_valid: byte_valid_i, last: last_i});
      if (pending_words.size() != 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        msg_word_t m;
        m = pending_words.pop_front();
        in_valid_i   <= 1'b1;
        data_byte_i  <= m.data_byte;
        byte_valid_i <= m.byte_valid;
        last_i       <= m.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: checks every accepted digest word, randomizes stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (digest_queue.size() == 0) begin
          $error("digest word with none expected: %h", digest_word_o);
          errors++;
        end else begin
          digest_t e;
          e = digest_queue.pop_front();
          if (digest_word_o !== e.digest_word) begin
            $error("digest_word exp %h got %h", e.digest_word, digest_word_o);
            errors++;
          end
          if (digest_pos_o !== e.digest_pos) begin
            $error("digest_pos exp %0d got %0d", e.digest_pos, digest_pos_o);
            errors++;
          end
          if (last_word_o !== e.last_word) begin
            $error("last_word exp %0d got %0d", e.last_word, last_word_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    msg_word_t m;
    int len;
    hold_send = 1'b0;
    set_phase(PH_NONE);
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty message, ignored word, byte with last, extremes
    push_message(0, 1'b0);
    m = '{data_byte: 8'hff, byte_valid: 1'b0, last: 1'b0};
    queue_word(m);
    queue_word('{data_byte: 8'h00, byte_valid: 1'b1, last: 1'b1});
    queue_word('{data_byte: 8'hff, byte_valid: 1'b1, last: 1'b0});
    queue_word('{data_byte: 8'h00, byte_valid: 1'b0, last: 1'b1});
    push_message(3, 1'b1);
    wait_drained();

    // pause until all digests are out, then pad-boundary lengths:
    // 55 fits the length, 56 needs a second block, 64 with last on the
    // byte that fills the block
    hold_send = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_send = 1'b0;
    push_message(55, 1'b1);
    push_message(56, 1'b0);
    push_message(64, 1'b1);

    // random messages in the four idle phases, ignored words mixed in
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      set_phase(phase_e'(ph));
      for (int n = 0; n < 4; n++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
        if ($urandom_range(4) == 0)
          queue_word('{data_byte: 8'($urandom), byte_valid: 1'b0, last: 1'b0});
        push_message(len, 1'($urandom_range(1)));
      end
    end
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && digest_queue.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
